/* design/isc_pkg.sv */
// Shared sizes, types and codes for the image stack combiner.
// Used by isc_div, image_stack_combine and its testbench; depends on nothing else.
package isc_pkg;

    // Maximum number of samples held for one pixel
    localparam int DEPTH = 16;

    // Index into the sorted store, and a count that can hold DEPTH itself
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Exact sum of up to DEPTH signed 32-bit samples
    localparam int SUM_W = 32 + $clog2(DEPTH);

    // Window arithmetic: counts, reject values and their sums
    localparam int WIN_W = ((CNT_W > 5) ? CNT_W : 5) + 2;

    // Divider step counter
    localparam int DCNT_W = $clog2(SUM_W + 1);

    typedef logic signed [31:0]      sample_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [CNT_W-1:0]        count_t;
    typedef logic [IDX_W-1:0]        index_t;

    // Configuration register indexes
    typedef enum logic [1:0] {REG_MODE, REG_LOW, REG_HIGH, REG_DEPTH} reg_idx_t;

    // Combine modes
    typedef enum logic [1:0] {MODE_MEAN, MODE_MEDIAN, MODE_CLIP, MODE_CLIP_NZ} combine_mode_t;

endpackage

/* design/isc_div.sv */
// Serial signed divider: sum / count, truncated toward zero, one bit a cycle.
// Depends on isc_pkg for widths.
module isc_div import isc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  sum_t         dividend,
    input  count_t       divisor,
    output logic         done,
    output logic [31:0]  quotient
);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    count_t            div_reg, div_next;
    logic              neg_reg, neg_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    shifted;
    logic [SUM_W-1:0]  result;

    // One restoring step per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        if (start) begin
            quo_next = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_next = '0;
            div_next = divisor;
            neg_next = dividend[SUM_W-1];
            cnt_next = DCNT_W'(SUM_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (shifted >= {1'b0, div_reg}) begin
                rem_next = CNT_W'(shifted - {1'b0, div_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = CNT_W'(shifted);
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // Restore the sign of the quotient
    assign result   = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign quotient = result[31:0];
    assign done     = done_reg;

endmodule

/* design/image_stack_combine.sv */
// Top level of the image stack combiner: sorted sample store, sequencer,
// configuration registers and result register. Depends on isc_pkg, isc_div.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  sample  | s_valid s_ready s_sample                | in
//  result  | m_valid m_ready m_combined m_window_error| out
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// A sample is taken in ST_IDLE, then the insertion walk in ST_INSERT
// moves each larger stored entry up one slot and writes the sample into
// the freed slot. The sample that completes a stack adds the combine pass:
// median reads the middle entry; mean runs the serial divider; clipped
// mean sums the window entries, then divides, and mode 3 first counts the
// zero samples over the whole stack and settles the window.
// Synchronous active-low reset clears control state; the store needs no
// clearing pass. s_ready is low while an item is at work; a held result
// only stalls the sequencer at its final step.
module image_stack_combine import isc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_combined,
    output logic        m_window_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_INSERT = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_ZERO   = 8'b0000_1000,
        ST_WIN    = 8'b0001_0000,
        ST_SUM    = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    sample_t     sample_reg, sample_next;
    index_t      k_reg, k_next;
    count_t      count_reg, count_next;
    sum_t        sum_reg, sum_next;
    sum_t        acc_reg, acc_next;
    index_t      idx_reg, idx_next;
    index_t      start_reg, start_next;
    index_t      stop_reg, stop_next;
    count_t      z_reg, z_next;
    logic [31:0] res_reg, res_next;
    logic        err_reg, err_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_combined_reg;
    logic        m_err_reg;
    logic [1:0]  mode_reg;
    logic [4:0]  low_reg, high_reg, depth_reg;

    sample_t     store_reg [DEPTH];
    logic        st_we;
    index_t      st_wa;
    sample_t     st_wd;
    index_t      rd_addr;
    sample_t     rd_data;

    logic        div_start;
    sum_t        div_dividend;
    count_t      div_divisor;
    logic        div_done;
    logic [31:0] div_quot;

    count_t      depth_eff;
    count_t      count_inc;
    logic [WIN_W-1:0] w_start, w_stop, w_last, w_stop0;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_combined     = m_combined_reg;
    assign m_window_error = m_err_reg;

    // Clamp the configured depth into 1..DEPTH
    always_comb begin
        if (depth_reg == 5'd0) begin
            depth_eff = CNT_W'(1);
        end else if (32'(depth_reg) > DEPTH) begin
            depth_eff = CNT_W'(DEPTH);
        end else begin
            depth_eff = CNT_W'(depth_reg);
        end
    end

    assign rd_data   = store_reg[rd_addr];
    assign count_inc = count_reg + CNT_W'(1);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        k_next       = k_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        start_next   = start_reg;
        stop_next    = stop_reg;
        z_next       = z_reg;
        res_next     = res_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        st_we        = 1'b0;
        st_wa        = k_reg;
        st_wd        = sample_reg;
        rd_addr      = idx_reg;
        div_start    = 1'b0;
        div_dividend = sum_reg;
        div_divisor  = count_reg;
        w_last       = WIN_W'(count_reg) - WIN_W'(1);
        w_stop0      = w_last - WIN_W'(high_reg);
        w_start      = WIN_W'(z_reg) + WIN_W'(low_reg);
        w_stop       = WIN_W'(stop_reg);

        // Drop the result once the consumer takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = sample_t'(s_sample);
                    sum_next    = sum_reg + SUM_W'(sample_t'(s_sample));
                    if (32'(count_reg) >= DEPTH) begin
                        count_next = CNT_W'(DEPTH - 1);
                        k_next     = IDX_W'(DEPTH - 1);
                    end else begin
                        k_next     = IDX_W'(count_reg);
                    end
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                // Walk down, moving larger entries up one slot
                rd_addr = k_reg - IDX_W'(1);
                st_we   = 1'b1;
                st_wa   = k_reg;
                if (k_reg != '0 && rd_data > sample_reg) begin
                    st_wd  = rd_data;
                    k_next = k_reg - IDX_W'(1);
                end else begin
                    st_wd      = sample_reg;
                    count_next = count_inc;
                    state_next = (count_inc >= depth_eff) ? ST_CHECK : ST_IDLE;
                end
            end
            ST_CHECK: begin
                rd_addr  = IDX_W'(count_reg >> 1);
                err_next = 1'b0;
                if (mode_reg == MODE_MEAN) begin
                    div_start    = 1'b1;
                    div_dividend = sum_reg;
                    div_divisor  = count_reg;
                    state_next   = ST_DIV;
                end else if (mode_reg == MODE_MEDIAN) begin
                    res_next   = rd_data;
                    state_next = ST_OUT;
                end else if (WIN_W'(low_reg) + WIN_W'(high_reg) >= WIN_W'(count_reg)) begin
                    res_next   = '0;
                    err_next   = 1'b1;
                    state_next = ST_OUT;
                end else if (mode_reg == MODE_CLIP) begin
                    start_next = IDX_W'(low_reg);
                    stop_next  = IDX_W'(w_stop0);
                    idx_next   = IDX_W'(low_reg);
                    acc_next   = '0;
                    state_next = ST_SUM;
                end else begin
                    stop_next  = IDX_W'(w_stop0);
                    idx_next   = '0;
                    z_next     = '0;
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                // Count exact-zero samples over the whole stack
                if (rd_data == '0) begin
                    z_next = z_reg + CNT_W'(1);
                end
                idx_next = idx_reg + IDX_W'(1);
                if (WIN_W'(idx_reg) == w_last) begin
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                // Fall back when the zero skip swallows the window
                if (w_start >= w_stop) begin
                    w_start = WIN_W'(z_reg);
                end
                if (w_start > w_stop) begin
                    w_stop = w_last;
                end
                if (w_start > w_stop) begin
                    w_start = w_last;
                end
                start_next = IDX_W'(w_start);
                stop_next  = IDX_W'(w_stop);
                idx_next   = IDX_W'(w_start);
                acc_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // Accumulate one window entry a cycle
                acc_next = acc_reg + SUM_W'(rd_data);
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == stop_reg) begin
                    div_start    = 1'b1;
                    div_dividend = acc_next;
                    div_divisor  = CNT_W'(stop_reg) - CNT_W'(start_reg) + CNT_W'(1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next   = div_quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    sum_next     = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
            mode_reg    <= MODE_MEAN;
            low_reg     <= 5'd1;
            high_reg    <= 5'd1;
            depth_reg   <= 5'd16;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MODE:  mode_reg  <= cfg_data[1:0];
                    REG_LOW:   low_reg   <= cfg_data;
                    REG_HIGH:  high_reg  <= cfg_data;
                    REG_DEPTH: depth_reg <= cfg_data;
                    default:   mode_reg  <= mode_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        idx_reg    <= idx_next;
        start_reg  <= start_next;
        stop_reg   <= stop_next;
        z_reg      <= z_next;
        res_reg    <= res_next;
        err_reg    <= err_next;
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_combined_reg <= res_reg;
            m_err_reg      <= err_reg;
        end
    end

    // Sorted sample store
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_reg[st_wa] <= st_wd;
        end
    end

    isc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= DEPTH)
        else $error("sample count beyond store depth");

    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    a_error_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_window_error) |-> m_combined == 32'd0)
        else $error("window error with nonzero result");

    a_accept_inserts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_INSERT)
        else $error("accepted request did not start insertion");
`endif

endmodule

/* dv/tb_image_stack_combine.sv */
// Self-checking testbench for image_stack_combine: directed table, then random stacks.
// Depends on isc_pkg and the image_stack_combine RTL; checks every result against
// a predictor of the sorted stack and its combine modes, or a typed table result.
module tb_image_stack_combine import isc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] combined;
        logic        window_error;
    } pixel_result_t;

    typedef struct packed {
        bit          is_cfg;
        reg_idx_t    ridx;
        logic [4:0]  rdata;
        logic [31:0] smp;
        bit          typed;
        logic [31:0] t_comb;
        bit          t_err;
    } plan_row_t;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int PLAN_LEN      = 35;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_sample = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_combined;
    logic        m_window_error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;

    // Idling controls; the receiver process owns hold_seen and hold_left
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int fail_count = 0;

    // Predictor state, at its reset values
    sample_t       stack_q [DEPTH];
    int            held = 0;
    longint        stack_sum = 0;
    combine_mode_t mode_r = MODE_MEAN;
    logic [4:0]    low_r = 5'd1;
    logic [4:0]    high_r = 5'd1;
    logic [4:0]    depth_r = 5'd16;

    pixel_result_t pending_pixels [$];
    pixel_result_t want;

    // Directed stimulus; typed results only where they are obvious
    plan_row_t plan [PLAN_LEN] = '{
        '{1'b1, REG_DEPTH, 5'd1, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h80000000, 1'b1, 32'h80000000, 1'b0},
        '{1'b1, REG_MODE, 5'(MODE_MEDIAN), 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{1'b1, REG_MODE, 5'(MODE_CLIP), 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h00010000, 1'b1, 32'h0, 1'b1},
        '{1'b1, REG_DEPTH, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h12345678, 1'b1, 32'h0, 1'b1},
        '{1'b1, REG_LOW, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_HIGH, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h80000000, 1'b1, 32'h80000000, 1'b0},
        '{1'b1, REG_MODE, 5'(MODE_CLIP_NZ), 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h0, 1'b1, 32'h0, 1'b0},
        '{1'b1, REG_DEPTH, 5'd4, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_LOW, 5'd1, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_HIGH, 5'd1, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h00050000, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h00070000, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_MODE, 5'(MODE_MEAN), 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h7FFFFFFE, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_MODE, 5'(MODE_MEDIAN), 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h80000000, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h00000001, 1'b0, 32'h0, 1'b0},
        '{1'b1, REG_DEPTH, 5'd2, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, REG_MODE, 5'd0, 32'h0, 1'b0, 32'h0, 1'b0}
    };

    image_stack_combine DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_combined    (m_combined),
        .m_window_error(m_window_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running 10 ns clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Clamp the configured depth into 1..DEPTH
    function automatic int eff_depth();
        int d;
        d = depth_r;
        if (d < 1) d = 1;
        if (d > DEPTH) d = DEPTH;
        return d;
    endfunction

    // Mean of sorted entries first..last, truncated toward zero
    function automatic sample_t window_mean(input int first, input int last);
        longint acc;
        acc = 0;
        for (int k = first; k <= last; k++) acc += stack_q[k];
        return sample_t'(acc / longint'(last - first + 1));
    endfunction

    // Insert one sample into the sorted stack; return 1 and the result when it completes
    function automatic bit absorb_sample(input sample_t v, output pixel_result_t r);
        int k;
        int n;
        int first;
        int last;
        int zeros;
        sample_t res;
        logic err;
        r = '0;
        if (held >= DEPTH) held = DEPTH - 1;
        k = held;
        while (k > 0 && stack_q[k-1] > v) begin
            stack_q[k] = stack_q[k-1];
            k--;
        end
        stack_q[k] = v;
        held++;
        stack_sum += v;
        if (held < eff_depth()) return 1'b0;

        n = held;
        res = '0;
        err = 1'b0;
        case (mode_r)
            MODE_MEAN: begin
                res = sample_t'(stack_sum / longint'(n));
            end
            MODE_MEDIAN: begin
                res = stack_q[n/2];
            end
            default: begin
                first = low_r;
                last = n - 1 - int'(high_r);
                if (first > last) begin
                    err = 1'b1;
                end else if (mode_r == MODE_CLIP) begin
                    res = window_mean(first, last);
                end else begin
                    // Skip the zero samples at the low end, with fallbacks
                    zeros = 0;
                    for (k = 0; k < n; k++) if (stack_q[k] == 0) zeros++;
                    first = zeros + int'(low_r);
                    if (first >= last) first = zeros;
                    if (first > last) last = n - 1;
                    if (first > last) first = n - 1;
                    res = window_mean(first, last);
                end
            end
        endcase
        held = 0;
        stack_sum = 0;
        r.combined = res;
        r.window_error = err;
        return 1'b1;
    endfunction

    // Mix of zeros, extremes, tiny values with repeats, mid-range and full-range values
    function automatic sample_t pick_sample();
        sample_t v;
        case ($urandom_range(0, 9))
            0, 1: v = '0;
            2:    v = 32'h7FFFFFFF;
            3:    v = 32'h80000000;
            4, 5: v = sample_t'($urandom_range(0, 6)) - 3;
            6:    v = sample_t'($urandom) >>> 12;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Send one sample request; record what it should produce
    task automatic push_sample(input logic [31:0] v, input bit typed,
                               input pixel_result_t typed_res);
        pixel_result_t res;
        cfg_valid <= 1'b0;
        while (tx_idle && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (absorb_sample(sample_t'(v), res))
            pending_pixels.push_back(typed ? typed_res : res);
    endtask

    // Write one register; valid stays up for a following write
    task automatic write_reg(input reg_idx_t idx, input logic [4:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_MODE:  mode_r = combine_mode_t'(data[1:0]);
            REG_LOW:   low_r = data;
            REG_HIGH:  high_r = data;
            REG_DEPTH: depth_r = data;
            default:   ;
        endcase
    endtask

    // Hold the sender until every result is back and a sample still inserting is done
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random idling, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_idle && $urandom_range(0, 99) < 8);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result: combined %h window_error %b",
                       m_combined, m_window_error);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_combined !== want.combined) begin
                    $error("combined: expected %h, actual %h", want.combined, m_combined);
                    fail_count++;
                end
                if (m_window_error !== want.window_error) begin
                    $error("window_error: expected %b, actual %b",
                           want.window_error, m_window_error);
                    fail_count++;
                end
            end
        end
    end

    // Timeout
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus
    initial begin
        int sent;
        int phase;
        int n_items;
        int eff;
        bit quiet;
        pixel_result_t typed_res;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].is_cfg) begin
                wait_results_drained();
                write_reg(plan[i].ridx, plan[i].rdata);
            end else begin
                typed_res.combined = plan[i].t_comb;
                typed_res.window_error = plan[i].t_err;
                push_sample(plan[i].smp, plan[i].typed, typed_res);
            end
        end

        // Random phases: new settings, then whole stacks, sometimes a partial one
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_results_drained();
            quiet = (phase >= 5 && phase < 10);
            tx_idle <= !quiet;
            rx_idle <= !quiet;
            if (phase == 2) begin
                // Stall the receiver while one-sample stacks keep arriving
                write_reg(REG_MODE, 5'(MODE_MEAN));
                write_reg(REG_DEPTH, 5'd1);
                hold_req <= hold_req + 1;
                for (int j = 0; j < 40; j++) begin
                    push_sample(pick_sample(), 1'b0, '0);
                    sent++;
                end
            end else begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_MODE, 5'($urandom_range(0, 3)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_LOW, ($urandom_range(0, 9) < 8) ?
                              5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_HIGH, ($urandom_range(0, 9) < 8) ?
                              5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31)));
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0:       write_reg(REG_DEPTH, 5'd0);
                        1:       write_reg(REG_DEPTH, 5'($urandom_range(17, 31)));
                        2, 3:    write_reg(REG_DEPTH, 5'($urandom_range(6, 16)));
                        default: write_reg(REG_DEPTH, 5'($urandom_range(1, 5)));
                    endcase
                end
                eff = eff_depth();
                n_items = (eff > 8) ? $urandom_range(1, 3) * eff : $urandom_range(2, 6) * eff;
                // Leave a partial stack behind for the next depth setting
                if (eff > 1 && $urandom_range(0, 3) == 0)
                    n_items += $urandom_range(1, eff - 1);
                for (int j = 0; j < n_items; j++) begin
                    push_sample(pick_sample(), 1'b0, '0);
                    sent++;
                end
            end
            phase++;
        end

        wait_results_drained();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
design/isc_pkg.sv
design/isc_div.sv
design/image_stack_combine.sv
dv/tb_image_stack_combine.sv
